### rtl/multiplexed_rgb_pwm_driver_unit_assert.svh
// Assertion macros used by the RTL of the RGB PWM driver.
`ifndef MULTIPLEXED_RGB_PWM_DRIVER_UNIT_ASSERT_SVH
`define MULTIPLEXED_RGB_PWM_DRIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRGBPWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRGBPWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mrgbpwm_pkg.sv
`default_nettype none

package mrgbpwm_pkg;

   localparam int DUTY_W   = 16;
   localparam int QUOT_W   = 12;
   localparam int BRI_W    = 5;
   localparam int COLOR_W  = 8;
   localparam int CHAN_W   = 2;
   localparam int COUNT_W  = 3;
   localparam int ANODE_W  = 4;
   localparam int PINS_W   = 3;

   // Item kinds carried in tuser.
   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [DUTY_W-1:0] POS_MAX = 16'hffff;
   localparam logic [7:0]        LOW_FILL = 8'hff;

   // floor(t / 31) == (t * RECIP_31) >> RECIP_SHIFT for every 16-bit t.
   localparam logic [16:0] RECIP_31    = 17'd67651;
   localparam int          RECIP_SHIFT = 21;

   typedef logic [DUTY_W-1:0] duty_type;
   typedef duty_type [PINS_W-1:0] rgb_duty_type;

   typedef struct packed {
      logic [PINS_W-1:0] colour;
      duty_type          cmp_point;
      duty_type          reload;
   } tick_eval_type;

endpackage

`default_nettype wire

### rtl/mrgbpwm_tick_eval.sv
`default_nettype none

// Compare the shown channel's duties against the timer position: drop pins
// whose duty has been passed, pick the next compare point, form the reload.
module mrgbpwm_tick_eval (
   input  wire mrgbpwm_pkg::rgb_duty_type  duties,
   input  wire mrgbpwm_pkg::duty_type      pos,
   input  wire [mrgbpwm_pkg::PINS_W-1:0]   colour_base,
   output mrgbpwm_pkg::tick_eval_type      result
);

   mrgbpwm_pkg::duty_type cmp_point;
   logic [mrgbpwm_pkg::PINS_W-1:0] colour;

   always_comb begin
      cmp_point = mrgbpwm_pkg::POS_MAX;
      for (int k = 0; k < mrgbpwm_pkg::PINS_W; k++) begin
         colour[k] = colour_base[k] && (duties[k] > pos);
         if ((duties[k] > pos) && (duties[k] < cmp_point)) begin
            cmp_point = duties[k];
         end
      end
   end

   assign result.colour    = colour;
   assign result.cmp_point = cmp_point;
   assign result.reload    = mrgbpwm_pkg::POS_MAX - (cmp_point - pos);

endmodule

`default_nettype wire

### rtl/multiplexed_rgb_pwm_driver_unit.sv
`default_nettype none

// Time-multiplexed PWM driver for up to NUM_CHANNELS common-anode RGB LEDs
// sharing one set of red, green and blue cathode pins. A set beat (tuser 0)
// scales a channel's 8-bit colors by a 5-bit brightness into 16-bit duties
// and stores them; it returns nothing. A tick beat (tuser 1) stands for one
// overflow of a 16-bit timer and returns one beat with the anode levels
// (0 = channel on), the color pin levels, the timer reload value that puts
// the next overflow on the next compare point, and the channel shown. When
// the position sits at 65535 a tick wraps it and moves the display to the
// next connected channel (csr_data sets how many: 0 acts as 1, values above
// NUM_CHANNELS act as NUM_CHANNELS). Write csr_data only while the block is
// idle. The block takes one beat per cycle unless stalled: the divide by 31
// is done by a reciprocal multiply on the way into the input register, and
// the brightness multiply, duty compare and state update work from that
// register, so a tick's result beat passes through the input register and
// the result register in that order. Only a tick that finds the result
// register full and not being drained stalls the input. The duty store
// resets to zero at once; no clearing pass follows reset.
module multiplexed_rgb_pwm_driver_unit #(
   parameter int NUM_CHANNELS = 4
) (
   input  wire        clock,
   input  wire        reset,
   // tdata: channel[1:0], brightness[6:2], red[14:7], green[22:15], blue[30:23]
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [31:0] req_tdata,
   // tuser: kind[0]
   input  wire [0:0]  req_tuser,
   // tdata: anode_levels[3:0], colour_levels[6:4], reload_value[22:7],
   //        active_channel[24:23]
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  wire        csr_valid,
   output logic       csr_ready,
   // channel_count
   input  wire [2:0]  csr_data
);

`include "multiplexed_rgb_pwm_driver_unit_assert.svh"

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // ---------------------------------------------------------------
   // Input register: hold one beat with its colors already divided
   // ---------------------------------------------------------------
   typedef struct packed {
      logic                                           kind;
      logic [mrgbpwm_pkg::CHAN_W-1:0]                 channel;
      logic [mrgbpwm_pkg::BRI_W-1:0]                  bri;
      logic [mrgbpwm_pkg::PINS_W-1:0][mrgbpwm_pkg::QUOT_W-1:0] quot;
   } in_beat_type;

   logic        in_valid_ff, in_valid_in;
   in_beat_type in_ff, in_in;
   logic        advance;
   logic        is_tick;

   always_comb begin
      logic [mrgbpwm_pkg::COLOR_W-1:0] c;
      logic [mrgbpwm_pkg::DUTY_W-1:0]  t;
      logic [32:0]                     prod;
      in_in.kind    = req_tuser[0];
      in_in.channel = req_tdata[1:0];
      in_in.bri     = req_tdata[6:2];
      for (int k = 0; k < mrgbpwm_pkg::PINS_W; k++) begin
         c    = req_tdata[7 + 8*k +: 8];
         t    = {c, mrgbpwm_pkg::LOW_FILL};
         prod = 33'(t) * 33'(mrgbpwm_pkg::RECIP_31);
         // A zero color stays dark whatever the brightness.
         in_in.quot[k] = (c == '0) ? '0
                         : prod[mrgbpwm_pkg::RECIP_SHIFT +: mrgbpwm_pkg::QUOT_W];
      end
   end

   assign is_tick    = (in_ff.kind == mrgbpwm_pkg::KIND_TICK);
   // A set beat always retires; a tick waits for room in the result register.
   assign advance    = in_valid_ff && (!is_tick || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= in_in;
      end
   end

   // ---------------------------------------------------------------
   // Channel count register
   // ---------------------------------------------------------------
   logic [mrgbpwm_pkg::COUNT_W-1:0] count_ff;
   logic [mrgbpwm_pkg::COUNT_W-1:0] present;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= mrgbpwm_pkg::COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   always_comb begin
      present = count_ff;
      if (count_ff == '0) begin
         present = mrgbpwm_pkg::COUNT_W'(1);
      end else if (32'(count_ff) > NUM_CHANNELS) begin
         present = mrgbpwm_pkg::COUNT_W'(NUM_CHANNELS);
      end
   end

   // ---------------------------------------------------------------
   // Duty store and display state
   // ---------------------------------------------------------------
   mrgbpwm_pkg::rgb_duty_type duty_ff [NUM_CHANNELS];
   mrgbpwm_pkg::rgb_duty_type set_duties;
   logic                      set_hit;
   logic [CH_W-1:0]           set_row;

   mrgbpwm_pkg::duty_type     pos_ff, pos_in;
   logic [CH_W-1:0]           cur_ff, cur_in;
   logic [NUM_CHANNELS-1:0]   anode_ff, anode_in;
   logic [mrgbpwm_pkg::PINS_W-1:0] colour_ff, colour_in;

   // Scale the stored quotients by brightness; keep the low 16 bits.
   always_comb begin
      logic [mrgbpwm_pkg::QUOT_W+mrgbpwm_pkg::BRI_W-1:0] scaled;
      for (int k = 0; k < mrgbpwm_pkg::PINS_W; k++) begin
         scaled        = (mrgbpwm_pkg::QUOT_W + mrgbpwm_pkg::BRI_W)'(in_ff.quot[k])
                         * (mrgbpwm_pkg::QUOT_W + mrgbpwm_pkg::BRI_W)'(in_ff.bri);
         set_duties[k] = scaled[mrgbpwm_pkg::DUTY_W-1:0];
      end
   end

   // Drop sets aimed past the last slot.
   assign set_hit = advance && !is_tick && (32'(in_ff.channel) < NUM_CHANNELS);
   assign set_row = CH_W'(in_ff.channel);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_CHANNELS; r++) begin
            duty_ff[r] <= '0;
         end
      end else if (set_hit) begin
         duty_ff[set_row] <= set_duties;
      end
   end

   // ---------------------------------------------------------------
   // Tick: wrap, channel advance, compare
   // ---------------------------------------------------------------
   logic                      wrap;
   mrgbpwm_pkg::duty_type     pos_eff;
   logic [CH_W:0]             nxt_wide;
   logic [CH_W-1:0]           nxt_ch;
   logic [CH_W-1:0]           row_idx;
   mrgbpwm_pkg::rgb_duty_type row;
   logic [mrgbpwm_pkg::PINS_W-1:0] nonzero;
   logic [mrgbpwm_pkg::PINS_W-1:0] colour_base;
   logic [NUM_CHANNELS-1:0]   anode_next;
   mrgbpwm_pkg::tick_eval_type eval;

   assign wrap     = (pos_ff == mrgbpwm_pkg::POS_MAX);
   assign pos_eff  = wrap ? '0 : pos_ff;
   assign nxt_wide = {1'b0, cur_ff} + (CH_W + 1)'(1);
   assign nxt_ch   = (32'(nxt_wide) >= 32'(present)) ? '0 : nxt_wide[CH_W-1:0];
   assign row_idx  = wrap ? nxt_ch : cur_ff;
   assign row      = duty_ff[row_idx];

   always_comb begin
      for (int k = 0; k < mrgbpwm_pkg::PINS_W; k++) begin
         nonzero[k] = (row[k] != '0);
      end
   end

   // On a wrap, switch off the old anode, switch on the new one and raise
   // every color that has a duty.
   assign colour_base = wrap ? (colour_ff | nonzero) : colour_ff;
   assign anode_next  = wrap
      ? ((anode_ff | (NUM_CHANNELS'(1) << cur_ff)) & ~(NUM_CHANNELS'(1) << nxt_ch))
      : anode_ff;

   mrgbpwm_tick_eval u_tick_eval (
      .duties      (row),
      .pos         (pos_eff),
      .colour_base (colour_base),
      .result      (eval)
   );

   always_comb begin
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      anode_in  = anode_ff;
      colour_in = colour_ff;
      if (advance && is_tick) begin
         pos_in    = eval.cmp_point;
         cur_in    = row_idx;
         anode_in  = anode_next;
         colour_in = eval.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cur_ff    <= '0;
         anode_ff  <= '1;
         colour_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         cur_ff    <= cur_in;
         anode_ff  <= anode_in;
         colour_ff <= colour_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [31:0] anode_ext;
   logic [31:0] cur_ext;

   assign anode_ext = 32'(anode_next);
   assign cur_ext   = 32'(row_idx);

   always_comb begin
      rsp_data_in = {7'd0,
                     cur_ext[1:0],
                     eval.reload,
                     eval.colour,
                     anode_ext[mrgbpwm_pkg::ANODE_W-1:0]};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && is_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `MRGBPWM_ASSERT_NOW(a_one_anode_on, clock, reset, 1'b1, $onehot0(~anode_ff), "two anodes on")
   `MRGBPWM_ASSERT_NEXT(a_tick_gives_beat, clock, reset,
      advance && is_tick, rsp_tvalid, "tick lost")
   `MRGBPWM_ASSERT_NEXT(a_pos_only_on_tick, clock, reset,
      !(advance && is_tick), $stable(pos_ff), "position moved without tick")
   `MRGBPWM_ASSERT_NEXT(a_hold_input, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_ff), "input beat lost")

endmodule

`default_nettype wire
